### hw/rtl/lzfw_pkg.sv
package lzfw_pkg;

   localparam int LANES = 4;

   typedef enum logic [2:0] {
      PH_CTRL1  = 3'd0,
      PH_CTRL2  = 3'd1,
      PH_SCOUNT = 3'd2,
      PH_LIT    = 3'd3,
      PH_SDIST  = 3'd4,
      PH_LLO    = 3'd5,
      PH_LHI    = 3'd6,
      PH_LCNT   = 3'd7
   } phase_type;

   typedef struct packed {
      logic        lit_wr;
      logic [7:0]  lit_byte;
      logic        cp_rd;
      logic        cp_wr;
      logic        load_dist;
      logic [13:0] dist_value;
      logic        load_len;
      logic [8:0]  len_value;
      logic        clear_produced;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_byte;
   } status_type;

endpackage

### hw/rtl/lz_flagbit_window_decompressor_unit.sv
// LZ decompressor with inline flag bytes and a HISTORY_DEPTH-byte history.
// Compressed bytes enter one per transfer on req_; decompressed bytes leave
// packed up to four to a transfer on rsp_, with rsp_tlast on the last result that
// an input byte causes. A flag byte is decoded bit by bit, and a literal or a
// copy also decodes the flag bits that trail it. A copy of N bytes reads each
// byte from the single-port history and then writes it back (overlapping
// copies work). A byte write waits while a result is held for rsp_tready, so
// a stalled receiver stretches literals and copies. Bytes that reach back
// before the start of the stream read as zero. The parser and the produced
// count clear after the byte marked by req_tlast.
module lz_flagbit_window_decompressor_unit
   import lzfw_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // byte_lane0..byte_lane3, lane_count, zero pad
   output logic        rsp_tlast    // run_last
);

   cmd_type    cmd;
   status_type status;

   lzfw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   lzfw_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/lzfw_ctrl.sv
module lzfw_ctrl
   import lzfw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {S_IDLE, S_BITS, S_LIT, S_RD, S_WR} state_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  flag_ff, flag_in;
   logic [3:0]  bits_ff, bits_in;
   logic        partial_ff, partial_in;
   logic [7:0]  held_ff, held_in;
   logic [8:0]  len_ff, len_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eos_ff, eos_in;
   logic        bit_now;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      flag_in    = flag_ff;
      bits_in    = bits_ff;
      partial_in = partial_ff;
      held_in    = held_ff;
      len_in     = len_ff;
      byte_in    = byte_ff;
      eos_in     = eos_ff;
      bit_now    = flag_ff[0];
      cmd        = '0;
      cmd.lit_byte = byte_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata;
               eos_in  = req_tlast;
               state_in = S_BITS;
               case (phase_ff)
                  PH_CTRL1, PH_CTRL2, PH_SCOUNT: begin
                     flag_in = req_tdata;
                     bits_in = 4'd8;
                  end
                  PH_LIT: state_in = S_LIT;
                  PH_SDIST: begin
                     cmd.load_dist  = 1'b1;
                     cmd.dist_value = 14'({1'b0, ~req_tdata}) + 14'd1;
                     cmd.load_len   = 1'b1;
                     cmd.len_value  = len_ff;
                     state_in = S_RD;
                  end
                  PH_LLO: begin
                     held_in  = req_tdata;
                     phase_in = PH_LHI;
                  end
                  PH_LHI: begin
                     cmd.load_dist  = 1'b1;
                     cmd.dist_value = 14'({~req_tdata, ~held_ff[7:3]}) + 14'd1;
                     if (held_ff[2:0] == 3'd0) begin
                        phase_in = PH_LCNT;
                     end else begin
                        cmd.load_len  = 1'b1;
                        cmd.len_value = 9'(held_ff[2:0]) + 9'd2;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     cmd.load_len  = 1'b1;
                     cmd.len_value = 9'(req_tdata) + 9'd1;
                     state_in = S_RD;
                  end
               endcase
            end
         end
         S_BITS: begin
            if ((phase_ff == PH_CTRL1 || phase_ff == PH_CTRL2 || phase_ff == PH_SCOUNT)
                && bits_ff != 4'd0) begin
               flag_in = {1'b0, flag_ff[7:1]};
               bits_in = bits_ff - 4'd1;
               case (phase_ff)
                  PH_CTRL1: phase_in = bit_now ? PH_LIT : PH_CTRL2;
                  PH_CTRL2: begin
                     if (bit_now) begin
                        phase_in = PH_LLO;
                     end else begin
                        phase_in = PH_SCOUNT;
                        len_in   = 9'd0;
                     end
                  end
                  default: begin
                     if (len_ff == 9'd0) begin
                        partial_in = bit_now;
                        len_in     = 9'd1;
                     end else begin
                        len_in   = 9'({partial_ff, bit_now}) + 9'd2;
                        phase_in = PH_SDIST;
                     end
                  end
               endcase
            end else begin
               state_in = S_IDLE;
               if (eos_ff) begin
                  phase_in   = PH_CTRL1;
                  flag_in    = 8'd0;
                  bits_in    = 4'd0;
                  partial_in = 1'b0;
                  held_in    = 8'd0;
                  len_in     = 9'd0;
                  cmd.clear_produced = 1'b1;
               end
            end
         end
         S_LIT: begin
            if (status.out_free) begin
               cmd.lit_wr = 1'b1;
               phase_in   = PH_CTRL1;
               state_in   = S_BITS;
            end
         end
         S_RD: begin
            cmd.cp_rd = 1'b1;
            state_in  = S_WR;
         end
         S_WR: begin
            if (status.out_free) begin
               cmd.cp_wr = 1'b1;
               if (status.last_byte) begin
                  phase_in = PH_CTRL1;
                  state_in = S_BITS;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_CTRL1;
         flag_ff    <= 8'd0;
         bits_ff    <= 4'd0;
         partial_ff <= 1'b0;
         held_ff    <= 8'd0;
         len_ff     <= 9'd0;
         eos_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         flag_ff    <= flag_in;
         bits_ff    <= bits_in;
         partial_ff <= partial_in;
         held_ff    <= held_in;
         len_ff     <= len_in;
         eos_ff     <= eos_in;
      end
      byte_ff <= byte_in;
   end

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= 4'd8) else $error("flag bit count out of range");

   a_idle_ctrl_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && (phase_ff == PH_CTRL1 || phase_ff == PH_CTRL2 ||
       phase_ff == PH_SCOUNT)) |-> bits_ff == 4'd0)
      else $error("idle in control phase with flag bits left");

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR |-> ($past(state_ff) == S_RD || $past(state_ff) == S_WR))
      else $error("copy write without read");

endmodule

### hw/rtl/lzfw_datapath.sv
module lzfw_datapath
   import lzfw_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int PW = $clog2(HISTORY_DEPTH + 1);

   logic [7:0]    mem [HISTORY_DEPTH];
   logic [AW-1:0] wp_ff, wp_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [13:0]   dist_ff;
   logic [8:0]    remain_ff;
   logic [7:0]    rdata_ff;
   logic          zero_ff;
   logic [AW-1:0] rd_addr;
   logic [14:0]   wp_w, dist_w, prod_w;
   logic [7:0]    wr_byte;
   logic          wr_en, final_byte, emit;
   logic [7:0]    pack_ff [LANES];
   logic [2:0]    cnt_ff;
   logic [7:0]    out_ff [LANES];
   logic [2:0]    out_cnt_ff;
   logic          out_last_ff, out_valid_ff;

   assign wp_w   = 15'(wp_ff);
   assign dist_w = 15'(dist_ff);
   assign prod_w = 15'(prod_ff);
   assign rd_addr = (wp_w >= dist_w) ? AW'(wp_w - dist_w)
                                     : AW'(wp_w + 15'(HISTORY_DEPTH) - dist_w);

   assign wr_en      = cmd.lit_wr || cmd.cp_wr;
   assign wr_byte    = cmd.lit_wr ? cmd.lit_byte : (zero_ff ? 8'd0 : rdata_ff);
   assign final_byte = cmd.lit_wr || (remain_ff == 9'd1);
   assign emit       = wr_en && (final_byte || cnt_ff == 3'(LANES - 1));

   assign status.out_free  = !out_valid_ff || rsp_tready;
   assign status.last_byte = (remain_ff == 9'd1);

   assign wp_in = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign prod_in = (prod_ff == PW'(HISTORY_DEPTH)) ? prod_ff : prod_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wp_ff] <= wr_byte;
      if (cmd.cp_rd) begin
         rdata_ff <= mem[rd_addr];
         zero_ff  <= (dist_w == 15'd0) || (dist_w > prod_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         prod_ff      <= '0;
         cnt_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wp_ff  <= wp_in;
            cnt_ff <= emit ? 3'd0 : cnt_ff + 3'd1;
         end
         if (cmd.clear_produced) prod_ff <= '0;
         else if (wr_en) prod_ff <= prod_in;
         if (emit) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
      if (cmd.load_dist) dist_ff <= cmd.dist_value;
      if (cmd.load_len) remain_ff <= cmd.len_value;
      else if (cmd.cp_wr) remain_ff <= remain_ff - 9'd1;
      if (wr_en) pack_ff[cnt_ff[1:0]] <= wr_byte;
      if (emit) begin
         for (int i = 0; i < LANES; i++) begin
            if (3'(i) < cnt_ff) out_ff[i] <= pack_ff[i];
            else if (3'(i) == cnt_ff) out_ff[i] <= wr_byte;
            else out_ff[i] <= 8'd0;
         end
         out_cnt_ff  <= cnt_ff + 3'd1;
         out_last_ff <= final_byte;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_cnt_ff, out_ff[3], out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tlast  = out_last_ff;

   a_out_count: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_cnt_ff >= 3'd1 && out_cnt_ff <= 3'(LANES)))
      else $error("result lane count out of range");

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      32'(wp_ff) < HISTORY_DEPTH) else $error("write pointer out of range");

   a_prod_range: assert property (@(posedge clock) disable iff (reset)
      32'(prod_ff) <= HISTORY_DEPTH) else $error("produced count past depth");

endmodule

### dv/lz_flagbit_window_decompressor_checker.sv
`timescale 1ns / 1ps

module lz_flagbit_window_decompressor_checker
   import lzfw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          result_count
);

   typedef struct {
      logic [7:0] lane[4];
      logic [2:0] count;
      logic       run_last;
   } beat_type;

   beat_type    beats_q[$];
   logic [7:0]  hist[8192];
   logic [12:0] wr_ptr;
   logic [13:0] produced;
   logic [7:0]  flag_sr;
   logic [3:0]  flags_left;
   phase_type   phase;
   logic        part_bit;
   logic [7:0]  low_byte;
   logic [13:0] copy_dist;
   logic [8:0]  copy_len;
   beat_type    cur;
   int          cur_n;

   assign pending = beats_q.size();

   function automatic void clear_parser();
      flag_sr    = '0;
      flags_left = '0;
      phase      = PH_CTRL1;
      part_bit   = 1'b0;
      low_byte   = '0;
      copy_dist  = '0;
      copy_len   = '0;
      produced   = '0;
   endfunction

   function automatic void flush_beat();
      if (cur_n > 0) begin
         cur.count    = cur_n[2:0];
         cur.run_last = 1'b0;
         beats_q.push_back(cur);
      end
      cur_n = 0;
   endfunction

   function automatic void put_out(logic [7:0] v);
      if (cur_n == 0)
         for (int k = 0; k < 4; k++) cur.lane[k] = '0;
      cur.lane[cur_n] = v;
      cur_n++;
      if (cur_n == LANES) flush_beat();
   endfunction

   function automatic void write_hist(logic [7:0] v);
      hist[wr_ptr] = v;
      wr_ptr++;
      if (produced < 14'd8192) produced++;
      put_out(v);
   endfunction

   function automatic void do_copy();
      logic [7:0] v;
      for (int i = 0; i < copy_len; i++) begin
         v = 8'h00;
         if (copy_dist != 0 && copy_dist <= produced)
            v = hist[wr_ptr - copy_dist[12:0]];
         write_hist(v);
      end
      phase = PH_CTRL1;
   endfunction

   function automatic void decode_byte(logic [7:0] din, logic eos);
      logic        used;
      logic        fb;
      logic [15:0] w;
      int          n0;
      used  = 1'b0;
      n0    = beats_q.size();
      cur_n = 0;
      forever begin
         if (phase inside {PH_CTRL1, PH_CTRL2, PH_SCOUNT}) begin
            if (flags_left == 0) begin
               if (used) break;
               flag_sr    = din;
               flags_left = 4'd8;
               used       = 1'b1;
            end
            fb = flag_sr[0];
            flag_sr = flag_sr >> 1;
            flags_left--;
            case (phase)
               PH_CTRL1: phase = fb ? PH_LIT : PH_CTRL2;
               PH_CTRL2: begin
                  if (fb) phase = PH_LLO;
                  else begin
                     phase    = PH_SCOUNT;
                     copy_len = '0;
                  end
               end
               default: begin
                  if (copy_len == 0) begin
                     part_bit = fb;
                     copy_len = 9'd1;
                  end else begin
                     copy_len = {part_bit, fb} + 9'd2;
                     phase    = PH_SDIST;
                  end
               end
            endcase
         end else begin
            if (used) break;
            used = 1'b1;
            case (phase)
               PH_LIT: begin
                  write_hist(din);
                  phase = PH_CTRL1;
               end
               PH_SDIST: begin
                  copy_dist = {6'd0, ~din} + 14'd1;
                  do_copy();
               end
               PH_LLO: begin
                  low_byte = din;
                  phase    = PH_LHI;
               end
               PH_LHI: begin
                  w = {din, low_byte};
                  copy_dist = {1'b0, ~w[15:3]} + 14'd1;
                  if (low_byte[2:0] == 3'd0) phase = PH_LCNT;
                  else begin
                     copy_len = low_byte[2:0] + 9'd2;
                     do_copy();
                  end
               end
               default: begin
                  copy_len = din + 9'd1;
                  do_copy();
               end
            endcase
         end
      end
      flush_beat();
      if (beats_q.size() > n0) beats_q[$].run_last = 1'b1;
      if (eos) clear_parser();
   endfunction

   always @(posedge clock) begin
      beat_type e;
      if (reset) begin
         beats_q.delete();
         wr_ptr       = '0;
         fail_count   <= 0;
         result_count <= 0;
         clear_parser();
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (beats_q.size() == 0) begin
               $display("%0t: unexpected result tdata=%h tlast=%b", $time, rsp_tdata,
                        rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               e = beats_q.pop_front();
               if (rsp_tdata[31:0] != {e.lane[3], e.lane[2], e.lane[1], e.lane[0]}
                   || rsp_tdata[34:32] != e.count || rsp_tdata[39:35] != 5'd0
                   || rsp_tlast != e.run_last) begin
                  $display("%0t: mismatch lanes exp %h %h %h %h act %h %h %h %h", $time,
                           e.lane[0], e.lane[1], e.lane[2], e.lane[3], rsp_tdata[7:0],
                           rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[31:24]);
                  $display("%0t:   count exp %0d act %0d, pad act %h, last exp %b act %b",
                           $time, e.count, rsp_tdata[34:32], rsp_tdata[39:35],
                           e.run_last, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### dv/lz_flagbit_window_decompressor_unit_tb.sv
`timescale 1ns / 1ps

module lz_flagbit_window_decompressor_unit_tb;
   import lzfw_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          result_count;

   logic [7:0]  stream_q[$];
   int          flag_pos;
   int          flag_used;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          bytes_sent;
   int          streams_sent;
   int          idle_cycles;

   lz_flagbit_window_decompressor_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lz_flagbit_window_decompressor_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count)
   );

   always #1 clock = ~clock;

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // flag bytes are reserved in place when the next control bit is needed
   task automatic put_ctl(input logic b);
      if (flag_used == 8) begin
         flag_pos = stream_q.size();
         stream_q.push_back(8'($urandom_range(255)));
         flag_used = 0;
      end
      stream_q[flag_pos][flag_used] = b;
      flag_used++;
   endtask

   task automatic start_stream();
      stream_q.delete();
      flag_used = 8;
   endtask

   task automatic enc_literal(input logic [7:0] v);
      put_ctl(1'b1);
      stream_q.push_back(v);
   endtask

   task automatic enc_short(input int cnt, input logic [7:0] d);
      put_ctl(1'b0);
      put_ctl(1'b0);
      put_ctl(1'((cnt - 2) >> 1));
      put_ctl(1'(cnt - 2));
      stream_q.push_back(d);
   endtask

   task automatic enc_long(input int span, input logic [2:0] c, input logic [7:0] ext);
      logic [15:0] w;
      w = {~(13'(span - 1)), c};
      put_ctl(1'b0);
      put_ctl(1'b1);
      stream_q.push_back(w[7:0]);
      stream_q.push_back(w[15:8]);
      if (c == 3'd0) stream_q.push_back(ext);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++) begin
         @(negedge clock);
         if ($urandom_range(99) < send_idle_pct) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tdata  = stream_q[i];
         req_tlast  = (i == stream_q.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
      streams_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_stream();
      int kind;
      int r;
      start_stream();
      kind = $urandom_range(99);
      if (kind < 5) begin
         repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 12)) begin
            r = $urandom_range(99);
            if (r < 40)
               enc_literal(8'($urandom_range(255)));
            else if (r < 75)
               enc_short($urandom_range(2, 5), 8'($urandom_range(255)));
            else
               enc_long(($urandom_range(9) < 7) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 8192),
                        ($urandom_range(9) < 8) ? 3'($urandom_range(1, 7)) : 3'd0,
                        ($urandom_range(9) < 8) ? 8'($urandom_range(15))
                                                : 8'($urandom_range(255)));
         end
         // cut a command short at the end of the stream
         if (kind < 15 && stream_q.size() > 1)
            stream_q = stream_q[0:$urandom_range(stream_q.size() - 2)];
      end
      send_stream();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 64;
      bytes_sent    = 0;
      streams_sent  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes: literals, every short count, nearest and farthest reach
      start_stream();
      enc_literal(8'h00);
      enc_literal(8'hff);
      enc_short(2, 8'hff);
      enc_short(3, 8'hfe);
      enc_short(4, 8'h80);
      enc_short(5, 8'h00);
      enc_long(8192, 3'd7, 8'h00);
      enc_long(1, 3'd0, 8'h00);
      enc_long(3, 3'd0, 8'hff);
      enc_literal(8'h5a);
      send_stream();
      // long copy cut off after its low byte
      start_stream();
      enc_literal(8'h3c);
      enc_long(2, 3'd1, 8'h00);
      stream_q.pop_back();
      send_stream();
      // lone flag byte ending a stream
      start_stream();
      stream_q.push_back(8'h00);
      send_stream();
      drain();

      while (bytes_sent < 460) begin
         if (bytes_sent >= 180 && send_idle_pct == 23) begin
            drain();
            send_idle_pct = 64;
            recv_idle_pct = 23;
         end else if (bytes_sent >= 330 && send_idle_pct == 64) begin
            drain();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_stream();
      end
      drain();

      $display("Sent %0d bytes in %0d streams; checked %0d results across three idle mixes.",
               bytes_sent, streams_sent, result_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
hw/rtl/lzfw_pkg.sv
hw/rtl/lzfw_ctrl.sv
hw/rtl/lzfw_datapath.sv
hw/rtl/lz_flagbit_window_decompressor_unit.sv
dv/lz_flagbit_window_decompressor_checker.sv
dv/lz_flagbit_window_decompressor_unit_tb.sv
